/* src/intel_hex_record_encoder_core_defines.svh */
// Assertion macros shared by the encoder
`ifndef INTEL_HEX_RECORD_ENCODER_CORE_DEFINES_SVH
`define INTEL_HEX_RECORD_ENCODER_CORE_DEFINES_SVH

// Implication checked each clock, off during reset
`define IHEX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked each clock, off during reset
`define IHEX_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

`endif

/* src/ihex_pkg.sv */
`timescale 1ns / 1ps

package ihex_pkg;

    localparam int STORE_AW = 5;
    localparam int EOF_LEN = 12;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    localparam logic [7:0] EOF_TEXT [EOF_LEN] = '{
        8'h3A, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
        8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h0A
    };

    typedef enum logic [1:0] {
        MODE_DATA  = 2'd0,
        MODE_FLUSH = 2'd1,
        MODE_EOF   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLON,
        ST_HDR,
        ST_DATA,
        ST_SUM,
        ST_NL,
        ST_EOF
    } state_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } store_req_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

/* src/ihex_store.sv */
`timescale 1ns / 1ps

module ihex_store
    import ihex_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic       aclk,
    input  store_req_t req,
    output logic [7:0] rd_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[IDX_W-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr[IDX_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/intel_hex_record_encoder_core.sv */
// A word that closes a record is accepted in ST_IDLE; ST_COLON then loads its first character into the output register.
// Throughput: a record of N bytes streams 2N+12 characters at one per cycle unless m_tready stalls, end of file
// adds 12; a word that closes nothing is taken in ST_IDLE, which stays ready. The emit sequencer sets the rate.
// The next word is taken once the final character sits in the output register.
// Reset (aresetn low, synchronous): empty record at address 0, output enabled.
`timescale 1ns / 1ps
`include "intel_hex_record_encoder_core_defines.svh"

module intel_hex_record_encoder_core
    import ihex_pkg::*;
#(
    parameter int RECORD_BYTES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte [7:0], address [23:8]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char [7:0]
    output logic        m_tlast
);

    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int CNT_W = $clog2(RECORD_BYTES + 1);

    state_t             state_reg, state_next;
    logic               oe_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [15:0]        load_addr_reg, load_addr_next;
    logic [7:0]         run_sum_reg, run_sum_next;
    logic [31:0]        hdr_reg, hdr_next;
    logic [7:0]         chk_reg, chk_next;
    logic [CNT_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic [IDX_W-1:0]   bidx_reg, bidx_next;
    logic               nib_reg, nib_next;
    logic [2:0]         hdr_cnt_reg, hdr_cnt_next;
    logic [3:0]         eof_idx_reg, eof_idx_next;
    logic               eof_pend_reg, eof_pend_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    store_req_t         store_req;
    logic [7:0]         rd_data;

    logic               accept;
    logic               adv;
    logic [7:0]         in_byte;
    logic [15:0]        in_addr;
    logic [7:0]         sum_add;
    logic [CNT_W-1:0]   cnt_inc;
    logic [15:0]        new_addr;
    logic               do_close;
    logic               do_restart;

    assign in_byte  = s_tdata[7:0];
    assign in_addr  = s_tdata[23:8];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign adv      = !m_valid_reg || m_tready;
    assign sum_add  = run_sum_reg + in_byte;
    assign cnt_inc  = count_reg + CNT_W'(1);

    ihex_store #(
        .DEPTH(RECORD_BYTES)
    ) u_store (
        .aclk   (aclk),
        .req    (store_req),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            oe_reg        <= 1'b1;
            count_reg     <= '0;
            load_addr_reg <= '0;
            run_sum_reg   <= '0;
            eof_pend_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                oe_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            load_addr_reg <= load_addr_next;
            run_sum_reg   <= run_sum_next;
            eof_pend_reg  <= eof_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg      <= hdr_next;
        chk_reg      <= chk_next;
        emit_cnt_reg <= emit_cnt_next;
        bidx_reg     <= bidx_next;
        nib_reg      <= nib_next;
        hdr_cnt_reg  <= hdr_cnt_next;
        eof_idx_reg  <= eof_idx_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        load_addr_next = load_addr_reg;
        run_sum_next   = run_sum_reg;
        hdr_next       = hdr_reg;
        chk_next       = chk_reg;
        emit_cnt_next  = emit_cnt_reg;
        bidx_next      = bidx_reg;
        nib_next       = nib_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        eof_idx_next   = eof_idx_reg;
        eof_pend_next  = eof_pend_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        store_req      = '0;
        do_close       = 1'b0;
        do_restart     = 1'b0;
        new_addr       = 16'd0;

        case (state_reg)
            ST_IDLE: begin
                if (accept && oe_reg) begin
                    case (mode_t'(s_tuser))
                        MODE_DATA: begin
                            store_req.we    = 1'b1;
                            store_req.waddr = STORE_AW'(count_reg[IDX_W-1:0]);
                            store_req.wdata = in_byte;
                            if (cnt_inc == CNT_W'(RECORD_BYTES)) begin
                                hdr_next      = {8'(cnt_inc), load_addr_reg, 8'h00};
                                chk_next      = 8'd0 - (sum_add + 8'(cnt_inc));
                                emit_cnt_next = cnt_inc;
                                eof_pend_next = 1'b0;
                                state_next    = ST_COLON;
                                do_restart    = 1'b1;
                                new_addr      = in_addr + 16'd1;
                            end else begin
                                count_next   = cnt_inc;
                                run_sum_next = sum_add;
                            end
                        end
                        MODE_FLUSH: begin
                            do_close      = (count_reg != '0);
                            do_restart    = 1'b1;
                            new_addr      = in_addr;
                            eof_pend_next = 1'b0;
                        end
                        MODE_EOF: begin
                            do_close      = (count_reg != '0);
                            do_restart    = 1'b1;
                            new_addr      = 16'd0;
                            eof_pend_next = 1'b1;
                            eof_idx_next  = 4'd0;
                            if (count_reg == '0) begin
                                state_next = ST_EOF;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (do_close) begin
                        hdr_next      = {8'(count_reg), load_addr_reg, 8'h00};
                        chk_next      = 8'd0 - (run_sum_reg + 8'(count_reg));
                        emit_cnt_next = count_reg;
                        state_next    = ST_COLON;
                    end
                    if (do_restart) begin
                        count_next     = '0;
                        load_addr_next = new_addr;
                        run_sum_next   = new_addr[15:8] + new_addr[7:0];
                    end
                end
            end
            ST_COLON: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_data_next  = CHAR_COLON;
                    m_last_next  = 1'b0;
                    hdr_cnt_next = 3'd0;
                    state_next   = ST_HDR;
                end
            end
            ST_HDR: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_data_next  = hex_char(hdr_reg[31:28]);
                    m_last_next  = 1'b0;
                    hdr_next     = {hdr_reg[27:0], 4'd0};
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_reg == 3'd7) begin
                        store_req.re    = 1'b1;
                        store_req.raddr = '0;
                        bidx_next       = '0;
                        nib_next        = 1'b0;
                        state_next      = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b0;
                    if (!nib_reg) begin
                        m_data_next = hex_char(rd_data[7:4]);
                        nib_next    = 1'b1;
                    end else begin
                        m_data_next = hex_char(rd_data[3:0]);
                        nib_next    = 1'b0;
                        if (CNT_W'(bidx_reg) == emit_cnt_reg - CNT_W'(1)) begin
                            state_next = ST_SUM;
                        end else begin
                            bidx_next       = bidx_reg + IDX_W'(1);
                            store_req.re    = 1'b1;
                            store_req.raddr = STORE_AW'(bidx_next);
                        end
                    end
                end
            end
            ST_SUM: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b0;
                    if (!nib_reg) begin
                        m_data_next = hex_char(chk_reg[7:4]);
                        nib_next    = 1'b1;
                    end else begin
                        m_data_next = hex_char(chk_reg[3:0]);
                        nib_next    = 1'b0;
                        state_next  = ST_NL;
                    end
                end
            end
            ST_NL: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_data_next  = CHAR_NL;
                    m_last_next  = !eof_pend_reg;
                    eof_idx_next = 4'd0;
                    state_next   = eof_pend_reg ? ST_EOF : ST_IDLE;
                end
            end
            ST_EOF: begin
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_data_next  = EOF_TEXT[eof_idx_reg];
                    m_last_next  = (eof_idx_reg == 4'(EOF_LEN - 1));
                    eof_idx_next = eof_idx_reg + 4'd1;
                    if (eof_idx_reg == 4'(EOF_LEN - 1)) begin
                        eof_pend_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `IHEX_ASSERT_ALWAYS(a_count_below_full, aclk, aresetn, count_reg < CNT_W'(RECORD_BYTES), "open record holds a full count")
    `IHEX_ASSERT_IMP(a_emit_nonempty, aclk, aresetn, state_reg == ST_DATA, emit_cnt_reg != '0, "data emission for an empty record")
    `IHEX_ASSERT_IMP(a_last_is_newline, aclk, aresetn, m_valid_reg && m_last_reg, m_data_reg == CHAR_NL, "final character is not a newline")
    `IHEX_ASSERT_IMP(a_read_when_emitting, aclk, aresetn, store_req.re, state_reg == ST_HDR || state_reg == ST_DATA, "store read outside record emission")

endmodule

/* dv/tb_intel_hex_record_encoder_core.sv */
`timescale 1ns / 1ps

module tb_intel_hex_record_encoder_core;
    import ihex_pkg::*;

    localparam int RECORD_BYTES = 16;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_A = 8'h41;
    localparam int SETTLE_CYCLES = 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_WORDS = 190;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } hex_text_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // data_byte [7:0], address [23:8]
    logic [1:0]  s_tuser = '0;   // mode [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // out_char [7:0]
    logic        m_tlast;

    hex_text_t   expected_text[$];
    logic [7:0]  rec_bytes[RECORD_BYTES];
    int          rec_count;
    logic [15:0] rec_addr;
    logic [7:0]  rec_sum;
    logic        hex_on;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          rx_hold = 1'b0;
    int          mismatches = 0;
    int          words_sent = 0;
    int          chars_checked = 0;
    int          records_seen = 0;
    int          quiet_cycles = 0;

    intel_hex_record_encoder_core #(
        .RECORD_BYTES(RECORD_BYTES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return ASCII_ZERO + {4'd0, nib};
        end
        return ASCII_A + {4'd0, nib} - 8'd10;
    endfunction

    function automatic void put_text(input logic [7:0] c);
        hex_text_t t;
        t.ch = c;
        t.last = 1'b0;
        expected_text.push_back(t);
    endfunction

    function automatic void put_hex_byte(input logic [7:0] v);
        put_text(ascii_nibble(v[7:4]));
        put_text(ascii_nibble(v[3:0]));
    endfunction

    function automatic void emit_record(input logic [15:0] next_addr);
        logic [7:0] cnt;
        cnt = 8'(rec_count);
        if (rec_count != 0) begin
            put_text(CHAR_COLON);
            put_hex_byte(cnt);
            put_hex_byte(rec_addr[15:8]);
            put_hex_byte(rec_addr[7:0]);
            put_hex_byte(8'h00);
            for (int i = 0; i < rec_count; i++) begin
                put_hex_byte(rec_bytes[i]);
            end
            put_hex_byte(8'h00 - (rec_sum + cnt));
            put_text(CHAR_NL);
        end
        rec_count = 0;
        rec_addr = next_addr;
        rec_sum = next_addr[15:8] + next_addr[7:0];
    endfunction

    function automatic void encode_word(input logic [1:0] mode, input logic [7:0] data,
                                        input logic [15:0] addr);
        int queued;
        hex_text_t t;
        queued = expected_text.size();
        if (!hex_on) begin
            return;
        end
        case (mode)
            MODE_DATA: begin
                rec_bytes[rec_count] = data;
                rec_sum = rec_sum + data;
                rec_count++;
                if (rec_count >= RECORD_BYTES) begin
                    emit_record(addr + 16'd1);
                end
            end
            MODE_FLUSH: begin
                emit_record(addr);
            end
            MODE_EOF: begin
                emit_record(16'h0000);
                put_text(CHAR_COLON);
                repeat (10) put_text(ASCII_ZERO);
                put_text(CHAR_NL);
            end
            default: begin
            end
        endcase
        if (expected_text.size() > queued) begin
            t = expected_text.pop_back();
            t.last = 1'b1;
            expected_text.push_back(t);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= 30) begin
            $display("mismatch at %0t: %s got %02h expected %02h", $realtime, what, got, want);
        end
    endtask

    task automatic send_word(input logic [1:0] mode, input logic [7:0] data,
                             input logic [15:0] addr);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {addr, data};
        s_tuser <= mode;
        do @(posedge aclk); while (!s_tready);
        encode_word(mode, data, addr);
        words_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_text.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_output_enable(input logic value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        hex_on = value;
    endtask

    task automatic send_run(input logic [15:0] start, input int len);
        logic [15:0] a;
        a = start;
        send_word(MODE_FLUSH, 8'($urandom_range(0, 255)), a);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                a = 16'($urandom_range(0, 65535));
            end
            send_word(MODE_DATA, 8'($urandom_range(0, 255)), a);
            a = a + 16'd1;
        end
    endtask

    task automatic test_directed();
        logic [15:0] a;
        write_output_enable(1'b1);
        send_word(MODE_EOF, 8'hFF, 16'hFFFF);
        send_word(MODE_FLUSH, 8'h00, 16'hFFFF);
        send_word(MODE_DATA, 8'h00, 16'hFFFF);
        send_word(MODE_DATA, 8'hFF, 16'h0000);
        send_word(MODE_DATA, 8'hA5, 16'h5A5A);
        send_word(MODE_SPARE, 8'hFF, 16'hFFFF);
        send_word(MODE_FLUSH, 8'hFF, 16'h0000);
        a = 16'hFFF0;
        send_word(MODE_FLUSH, 8'h00, a);
        for (int k = 0; k < RECORD_BYTES; k++) begin
            send_word(MODE_DATA, (k % 2 == 0) ? 8'hFF : 8'h00, a);
            a = a + 16'd1;
        end
        send_word(MODE_DATA, 8'h5A, 16'h1234);
        send_word(MODE_EOF, 8'h00, 16'h0000);
    endtask

    task automatic test_output_disabled();
        write_output_enable(1'b0);
        for (int k = 0; k < 12; k++) begin
            send_word(2'(k % 4), 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end
        write_output_enable(1'b1);
    endtask

    task automatic test_random_records(input int target);
        int done;
        int len;
        done = 0;
        while (done < target) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));
                    done++;
                end
                1: begin
                    send_word(MODE_EOF, 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));
                    done++;
                end
                default: begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                      : $urandom_range(1, 20);
                    send_run(16'($urandom_range(0, 65535)), len);
                    done += len + 1;
                end
            endcase
        end
    endtask

    task automatic test_output_backpressure();
        settle();
        tx_idle_on = 1'b0;
        rx_hold = 1'b1;
        send_run(16'hFFE8, 40);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_no_idle();
        settle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_run(16'h8000, 20);
        send_run(16'h7FF8, 12);
        send_word(MODE_EOF, 8'h00, 16'h0000);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_output_disabled();
        test_random_records(RANDOM_WORDS);
        test_output_backpressure();
        test_output_disabled();
        test_no_idle();
        settle();
        $display("covered %0d input words in all four modes with hex output on and off,",
                 words_sent);
        $display("%0d characters checked across %0d text lines, long output stall included",
                 chars_checked, records_seen);
        if (mismatches == 0 && expected_text.size() == 0) begin
            $display("tb_intel_hex_record_encoder_core: PASS");
        end else begin
            $display("tb_intel_hex_record_encoder_core: FAIL");
        end
        $finish;
    end

    initial begin
        int burst;
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (burst) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        hex_text_t want;
        if (aresetn && m_tvalid && m_tready) begin
            chars_checked++;
            if (m_tdata == CHAR_NL) begin
                records_seen++;
            end
            if (expected_text.size() == 0) begin
                report_mismatch("unexpected char", m_tdata, 8'h00);
            end else begin
                want = expected_text.pop_front();
                if (m_tdata !== want.ch) begin
                    report_mismatch("out_char", m_tdata, want.ch);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last_char", {7'd0, m_tlast}, {7'd0, want.last});
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("tb_intel_hex_record_encoder_core: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

/* filelist.f */
+incdir+src
src/ihex_pkg.sv
src/ihex_store.sv
src/intel_hex_record_encoder_core.sv
dv/tb_intel_hex_record_encoder_core.sv
